[design/sprq_pkg.sv]
// Package for the sorted priority request queue.
// Field widths, request and status codes, word and entry structs, controller states.
// No dependencies.
`default_nettype none

package sprq_pkg;

    localparam int ID_W         = 16;
    localparam int PRIO_W       = 4;
    localparam int CNT_OUT_W    = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_CHANGE = 2'd2,
        REQ_NONE   = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type          req_type;
        logic [ID_W-1:0]    req_id;
        logic [PRIO_W-1:0]  priority_req;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [ID_W-1:0]      out_id;
        logic [PRIO_W-1:0]    out_priority;
        logic [CNT_OUT_W-1:0] count;
    } t_res;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FWD,
        S_BSTART,
        S_BWD,
        S_BLAST,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[design/sprq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[design/sorted_priority_request_queue_core.sv]
// Sorted priority request queue: top level, walk controller and output register.
// Depends on sprq_pkg and sprq_ram.
//
// Entries live in one RAM, sorted by priority with the head at address 0; the newest of equal
// priorities sits ahead. One request is worked at a time, one RAM entry per cycle: an insert
// walks from the tail toward its slot, moving each lower entry down as it goes; a remove
// reads the head and walks the list up; a change of priority walks forward to the first
// matching id, closing the gap behind it, then runs the insert walk. The RAM's registered
// read data and its single write port set the pace of these walks. A finished result sits in
// an output register, so the next request is taken while the result still waits. count
// reports the low five bits.
`default_nettype none

module sorted_priority_request_queue_core
    import sprq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_req i_in_word,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_res      o_out_word
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = $bits(t_entry);

    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic              r_shift, n_shift;
    t_status           r_status, n_status;
    logic [ID_W-1:0]   r_rid, n_rid;
    logic [PRIO_W-1:0] r_rprio, n_rprio;
    t_res              r_out;
    logic              r_out_valid;

    logic              in_accept;
    logic              out_free;
    logic              fwd_last;
    logic              fwd_hit;
    logic              bwd_stop;
    t_entry            new_entry;
    t_entry            rd_entry;
    logic [ENT_W-1:0]  rd_data;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    t_entry            wr_entry;
    logic [PTR_W-1:0]  rd_addr;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign rd_entry    = t_entry'(rd_data);
    assign new_entry   = '{id: r_req.req_id, prio: r_req.priority_req};
    assign fwd_last    = (CNT_W'(r_ptr) + CNT_W'(1)) == r_count;
    assign fwd_hit     = !r_shift
                         && ((r_req.req_type == REQ_REMOVE) || (rd_entry.id == r_req.req_id));
    assign bwd_stop    = rd_entry.prio > r_req.priority_req;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    sprq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // next state and walk bookkeeping
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_shift  = r_shift;
        n_status = r_status;
        n_rid    = r_rid;
        n_rprio  = r_rprio;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_req    = i_in_word;
                    n_status = ST_OK;
                    n_rid    = '0;
                    n_rprio  = '0;
                    n_ptr    = '0;
                    n_shift  = 1'b0;
                    unique case (i_in_word.req_type)
                        REQ_INSERT: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_BSTART;
                            end
                        end
                        REQ_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_FWD;
                            end
                        end
                        REQ_CHANGE: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_FWD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_FWD: begin
                if (fwd_hit) begin
                    n_shift = 1'b1;
                    if (r_req.req_type == REQ_REMOVE) begin
                        n_rid   = rd_entry.id;
                        n_rprio = rd_entry.prio;
                    end
                end
                if (fwd_last) begin
                    if (r_shift || fwd_hit) begin
                        n_count = r_count - CNT_W'(1);
                        n_state = (r_req.req_type == REQ_CHANGE) ? S_BSTART : S_DONE;
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_ptr = r_ptr + PTR_W'(1);
                end
            end
            S_BSTART: begin
                if (r_count == '0) begin
                    n_state = S_BLAST;
                end else begin
                    n_ptr   = PTR_W'(r_count - CNT_W'(1));
                    n_state = S_BWD;
                end
            end
            S_BWD: begin
                if (bwd_stop) begin
                    n_count = r_count + CNT_W'(1);
                    n_state = S_DONE;
                end else if (r_ptr == '0) begin
                    n_state = S_BLAST;
                end else begin
                    n_ptr = r_ptr - PTR_W'(1);
                end
            end
            S_BLAST: begin
                n_count = r_count + CNT_W'(1);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // RAM access and handshake outputs
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        rd_addr    = r_ptr + PTR_W'(1);
        wr_en      = 1'b0;
        wr_addr    = r_ptr;
        wr_entry   = new_entry;
        unique case (r_state)
            S_IDLE: begin
                rd_addr = '0;
            end
            S_FWD: begin
                // close the gap: move the word read now one slot toward the head
                wr_en    = r_shift;
                wr_addr  = r_ptr - PTR_W'(1);
                wr_entry = rd_entry;
            end
            S_BSTART: begin
                rd_addr = PTR_W'(r_count - CNT_W'(1));
            end
            S_BWD: begin
                // drop the new word in above a higher entry, else push this one down
                rd_addr  = r_ptr - PTR_W'(1);
                wr_en    = 1'b1;
                wr_addr  = r_ptr + PTR_W'(1);
                wr_entry = bwd_stop ? new_entry : rd_entry;
            end
            S_BLAST: begin
                wr_en    = 1'b1;
                wr_addr  = '0;
                wr_entry = new_entry;
            end
            S_DONE: begin
                rd_addr = '0;
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_ptr    <= n_ptr;
        r_shift  <= n_shift;
        r_status <= n_status;
        r_rid    <= n_rid;
        r_rprio  <= n_rprio;
        if ((r_state == S_DONE) && out_free) begin
            r_out.status       <= r_status;
            r_out.out_id       <= r_rid;
            r_out.out_priority <= r_rprio;
            r_out.count        <= CNT_OUT_W'(r_count);
        end
    end

endmodule

`default_nettype wire
